@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on aclk, with or without the reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check that is switched off while aresetn is low
`define GVI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check that also holds through reset
`define GVI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define GVI_ASSERT(lbl, prop, msg)
`define GVI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/gvi_pkg.sv @@
// ----------------------------------------------------------------------------
// gvi_pkg
// shared types and constants of the grid value interpolator
// ----------------------------------------------------------------------------
package gvi_pkg;

    localparam int DIMS_DEF      = 3;
    localparam int CELL_BITS_DEF = 5;
    localparam int MAX_DIMS      = 3;
    localparam int DIM_W         = 2;
    localparam int FRAC_BITS     = 16;
    localparam int PRIO_FRAC     = 16;

    localparam int VAL_W     = 32;
    localparam int CELL_W    = 31;
    localparam int PRIO_W    = 17;
    localparam int OFF_W     = 3;
    localparam int ADDR_IN_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // shared divider geometry: 64 bit dividend, 33 bit divisor, 34 quotient bits
    localparam int DVD_W = 64;
    localparam int DVS_W = 33;
    localparam int QUO_W = 34;

    localparam logic [PRIO_W-1:0] PRIO_ONE = PRIO_W'(1 << PRIO_FRAC);
    localparam logic [VAL_W-1:0]  VAL_MAX  = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0]  VAL_MIN  = 32'h8000_0000;
    localparam logic [CELL_W-1:0] CELL_ONE = CELL_W'(1 << FRAC_BITS);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL   = 3'd7;

    // word kinds on tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // divider operand selection
    localparam logic [1:0] DIV_QUANT = 2'd0;
    localparam logic [1:0] DIV_TERM  = 2'd1;
    localparam logic [1:0] DIV_PRIO  = 2'd2;

    typedef struct packed {
        logic             mem_wr;
        logic             cap_query;
        logic             div_start;
        logic [1:0]       div_sel;
        logic             q_fix;
        logic             q_post;
        logic             rd_centre;
        logic             rd_nb;
        logic             nn_latch;
        logic             diff_latch;
        logic             mul_lo;
        logic             mul_hi;
        logic             sum;
        logic             term_acc;
        logic             sat;
        logic             prio_eval;
        logic             prio_latch;
        logic             out_load;
        logic [DIM_W-1:0] dim;
    } gvi_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic prio_div;
    } gvi_sts_t;

endpackage

@@ sv/grid_value_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// grid_value_interpolator_core
// voxel grid value table with first-order interpolation and priority
// ----------------------------------------------------------------------------
// a load word is written to the table at its acceptance; a query word runs through
// the sequencer from acceptance to the result word, and the priority division
// is skipped when the priority needs no division
// the time is set by the shared bit-serial divider: up to 2*DIMS + 1 divisions of
// 34 steps each, plus 1 + DIMS single-port table reads and two multiply steps
// per dimension; one query is in flight, loads wait until it has finished
// aresetn is synchronous, active low: it restores the register defaults and
// idles the sequencer; the value table is not cleared and holds old words
// ----------------------------------------------------------------------------
module grid_value_interpolator_core import gvi_pkg::*; #(
    parameter int DIMS      = DIMS_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // register write port, index per register map in the package
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [143:0]         s_tdata,  // table_addr, table_word, point_x, point_y, point_z
    input  logic                 s_tuser,  // cmd: 0 load, 1 query
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata   // interp_value, priority_res, off_grid
);

    gvi_cmd_t         cmd;
    gvi_sts_t         sts;
    logic [VAL_W-1:0]  out_value;
    logic [PRIO_W-1:0] out_prio;
    logic [OFF_W-1:0]  out_off;

    // sequencer; it owns both handshakes
    gvi_ctrl #(
        .DIMS (DIMS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath with the table, registers and divider
    gvi_dp #(
        .DIMS      (DIMS),
        .CELL_BITS (CELL_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .in_addr   (s_tdata[14:0]),
        .in_word   (s_tdata[46:15]),
        .in_px     (s_tdata[78:47]),
        .in_py     (s_tdata[110:79]),
        .in_pz     (s_tdata[142:111]),
        .out_value (out_value),
        .out_prio  (out_prio),
        .out_off   (out_off)
    );

    // result word packing, lowest field first, padded to whole bytes
    assign m_tdata = {4'b0, out_off, out_prio, out_value};

endmodule

@@ sv/gvi_div.sv @@
// ----------------------------------------------------------------------------
// gvi_div
// restoring divider, one quotient bit per cycle, 34 steps
// ----------------------------------------------------------------------------
module gvi_div import gvi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dvd,
    input  logic [DVS_W-1:0] dvs,
    output logic             busy,
    output logic             done,
    output logic [QUO_W-1:0] quot,
    output logic [DVS_W-1:0] rem
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    // caller keeps the top part of the dividend below the divisor
    always_comb begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DVS_W'(dvd[DVD_W-1:QUO_W]);
            quo_reg <= dvd[QUO_W-1:0];
            dvs_reg <= dvs;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

@@ sv/gvi_dp.sv @@
// ----------------------------------------------------------------------------
// gvi_dp
// datapath: registers, value table, multiplier, accumulator, shared divider
// ----------------------------------------------------------------------------
module gvi_dp import gvi_pkg::*; #(
    parameter int DIMS      = DIMS_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  gvi_cmd_t             cmd,
    output gvi_sts_t             sts,
    input  logic [ADDR_IN_W-1:0] in_addr,
    input  logic [VAL_W-1:0]     in_word,
    input  logic [VAL_W-1:0]     in_px,
    input  logic [VAL_W-1:0]     in_py,
    input  logic [VAL_W-1:0]     in_pz,
    output logic [VAL_W-1:0]     out_value,
    output logic [PRIO_W-1:0]    out_prio,
    output logic [OFF_W-1:0]     out_off
);

    localparam int ADDR_W = DIMS * CELL_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int VOX    = 1 << CELL_BITS;
    localparam int FQ_W   = QUO_W + 1;
    localparam int ACC_W  = 37;
    localparam int TRM_W  = QUO_W + 2;

    function automatic logic [CELL_BITS-1:0] clampq(input logic signed [FQ_W-1:0] x);
        logic [CELL_BITS-1:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > $signed(FQ_W'(VOX - 1))) begin
            r = '1;
        end else begin
            r = x[CELL_BITS-1:0];
        end
        return r;
    endfunction

    // configuration
    logic signed [VAL_W-1:0]  low_reg [MAX_DIMS];
    logic        [CELL_W-1:0] cs_reg  [MAX_DIMS];
    logic signed [VAL_W-1:0]  fl_reg, ce_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                low_reg[i] <= '0;
                cs_reg[i]  <= CELL_ONE;
            end
            fl_reg <= '0;
            ce_reg <= VAL_W'(PRIO_ONE);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LOW_X:  low_reg[0] <= cfg_wdata;
                REG_LOW_Y:  low_reg[1] <= cfg_wdata;
                REG_LOW_Z:  low_reg[2] <= cfg_wdata;
                REG_CELL_X: cs_reg[0]  <= cfg_wdata[CELL_W-1:0];
                REG_CELL_Y: cs_reg[1]  <= cfg_wdata[CELL_W-1:0];
                REG_CELL_Z: cs_reg[2]  <= cfg_wdata[CELL_W-1:0];
                REG_FLOOR:  fl_reg     <= cfg_wdata;
                REG_CEIL:   ce_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-query state
    logic signed [VAL_W-1:0]     pt_reg  [MAX_DIMS];
    logic        [CELL_BITS-1:0] cq_reg  [MAX_DIMS];
    logic        [CELL_BITS-1:0] nq_reg  [MAX_DIMS];
    logic        [CELL_W-1:0]    mag_reg [MAX_DIMS];
    logic        [OFF_W-1:0]     off_reg;
    logic signed [FQ_W-1:0]      fq_reg;
    logic        [CELL_W-1:0]    m_reg;
    logic                        neg_reg;
    logic        [VAL_W-1:0]     rd_data_reg, nn_reg;
    logic signed [VAL_W:0]       diff_reg;
    logic signed [49:0]          plo_reg;
    logic signed [48:0]          phi_reg;
    logic signed [64:0]          n_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic        [VAL_W-1:0]     v_reg;
    logic        [PRIO_W-1:0]    prio_reg;
    logic        [VAL_W-1:0]     out_value_reg;
    logic        [PRIO_W-1:0]    out_prio_reg;
    logic        [OFF_W-1:0]     out_off_reg;

    logic [CELL_W-1:0]      s_eff;
    logic signed [VAL_W:0]  rel;
    logic [VAL_W:0]         rel_mag;
    logic [DVD_W-1:0]       div_dvd;
    logic [DVS_W-1:0]       div_dvs;
    logic [QUO_W-1:0]       quo;
    logic [DVS_W-1:0]       rem;
    logic signed [64:0]     n_abs;
    logic signed [FQ_W-1:0] fq_calc;
    logic [CELL_W-1:0]      m_calc;
    logic signed [VAL_W:0]  a2, a2_neg;
    logic                   above;
    logic signed [TRM_W-1:0] tq, term;
    logic [VAL_W-1:0]       v_calc;
    logic signed [VAL_W:0]  pnum, pden;
    logic                   p_low, p_high, p_flat;
    logic [ADDR_W-1:0]      centre_idx, nb_idx, rd_addr;
    logic [CELL_W-1:0]      mag_cur;

    always_comb begin
        s_eff   = (cs_reg[cmd.dim] == '0) ? CELL_W'(1) : cs_reg[cmd.dim];
        rel     = $signed({pt_reg[cmd.dim][VAL_W-1], pt_reg[cmd.dim]})
                - $signed({low_reg[cmd.dim][VAL_W-1], low_reg[cmd.dim]});
        rel_mag = rel[VAL_W] ? VAL_W'(1) + ~rel : rel;
        n_abs   = n_reg[64] ? -n_reg : n_reg;
        pnum    = $signed({v_reg[VAL_W-1], v_reg}) - $signed({fl_reg[VAL_W-1], fl_reg});
        pden    = $signed({ce_reg[VAL_W-1], ce_reg}) - $signed({fl_reg[VAL_W-1], fl_reg});
        case (cmd.div_sel)
            DIV_QUANT: begin
                div_dvd = DVD_W'(rel_mag);
                div_dvs = DVS_W'(s_eff);
            end
            DIV_TERM: begin
                div_dvd = n_abs[DVD_W-1:0];
                div_dvs = DVS_W'({s_eff, 1'b0});
            end
            DIV_PRIO: begin
                div_dvd = DVD_W'({pnum, {PRIO_FRAC{1'b0}}});
                div_dvs = pden;
            end
            default: begin
                div_dvd = '0;
                div_dvs = DVS_W'(1);
            end
        endcase
    end

    gvi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dvd     (div_dvd),
        .dvs     (div_dvs),
        .busy    (sts.div_busy),
        .done    (sts.div_done),
        .quot    (quo),
        .rem     (rem)
    );

    // floor quotient and modulo from the unsigned result
    always_comb begin
        if (!neg_reg) begin
            fq_calc = $signed({1'b0, quo});
            m_calc  = rem[CELL_W-1:0];
        end else if (rem == '0) begin
            fq_calc = -$signed({1'b0, quo});
            m_calc  = '0;
        end else begin
            fq_calc = ~$signed({1'b0, quo});
            m_calc  = s_eff - rem[CELL_W-1:0];
        end
        a2     = $signed({1'b0, m_reg, 1'b0}) - $signed({2'b0, s_eff});
        a2_neg = -a2;
        above  = !a2[VAL_W];
        tq     = $signed({2'b0, quo});
        term   = neg_reg ? (~tq + TRM_W'(rem == '0)) : tq;
        if (acc_reg[ACC_W-1:VAL_W-1] == '0 || acc_reg[ACC_W-1:VAL_W-1] == '1) begin
            v_calc = acc_reg[VAL_W-1:0];
        end else begin
            v_calc = acc_reg[ACC_W-1] ? VAL_MIN : VAL_MAX;
        end
        p_low   = $signed(v_reg) < fl_reg;
        p_high  = $signed(v_reg) > ce_reg;
        p_flat  = ce_reg == fl_reg;
        mag_cur = mag_reg[cmd.dim];
    end

    assign sts.prio_div = !(p_low || p_high || p_flat);

    // row-major, dimension 0 most significant
    always_comb begin
        centre_idx = '0;
        nb_idx     = '0;
        for (int d = 0; d < DIMS; d++) begin
            centre_idx[(DIMS-1-d)*CELL_BITS +: CELL_BITS] = cq_reg[d];
            nb_idx[(DIMS-1-d)*CELL_BITS +: CELL_BITS] =
                (DIM_W'(d) == cmd.dim) ? nq_reg[d] : cq_reg[d];
        end
        rd_addr = cmd.rd_nb ? nb_idx : centre_idx;
    end

    // value table
    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[ADDR_W'(in_addr)] <= in_word;
        end
        if (cmd.rd_centre || cmd.rd_nb) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_query) begin
            pt_reg[0] <= in_px;
            pt_reg[1] <= in_py;
            pt_reg[2] <= in_pz;
            off_reg   <= '0;
        end
        if (cmd.div_start) begin
            case (cmd.div_sel)
                DIV_QUANT: neg_reg <= rel[VAL_W];
                DIV_TERM:  neg_reg <= n_reg[64];
                default:   neg_reg <= 1'b0;
            endcase
        end
        if (cmd.q_fix) begin
            fq_reg <= fq_calc;
            m_reg  <= m_calc;
        end
        if (cmd.q_post) begin
            cq_reg[cmd.dim]  <= clampq(fq_reg);
            nq_reg[cmd.dim]  <= clampq(above ? fq_reg + $signed(FQ_W'(1))
                                             : fq_reg - $signed(FQ_W'(1)));
            mag_reg[cmd.dim] <= above ? a2[CELL_W-1:0] : a2_neg[CELL_W-1:0];
            off_reg[cmd.dim] <= (fq_reg < 0) || (fq_reg > $signed(FQ_W'(VOX)))
                             || (fq_reg == $signed(FQ_W'(VOX)) && m_reg != '0);
        end
        if (cmd.nn_latch) begin
            nn_reg  <= rd_data_reg;
            acc_reg <= ACC_W'($signed(rd_data_reg));
        end
        if (cmd.diff_latch) begin
            diff_reg <= $signed({rd_data_reg[VAL_W-1], rd_data_reg})
                      - $signed({nn_reg[VAL_W-1], nn_reg});
        end
        if (cmd.mul_lo) begin
            plo_reg <= diff_reg * $signed({1'b0, mag_cur[15:0]});
        end
        if (cmd.mul_hi) begin
            phi_reg <= diff_reg * $signed({1'b0, mag_cur[CELL_W-1:16]});
        end
        if (cmd.sum) begin
            n_reg <= 65'(plo_reg) + (65'(phi_reg) <<< 16) + $signed({34'b0, s_eff});
        end
        if (cmd.term_acc) begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
        if (cmd.sat) begin
            v_reg <= v_calc;
        end
        if (cmd.prio_eval) begin
            prio_reg <= p_low ? '0 : PRIO_ONE;
        end
        if (cmd.prio_latch) begin
            prio_reg <= quo[PRIO_W-1:0];
        end
        if (cmd.out_load) begin
            out_value_reg <= v_reg;
            out_prio_reg  <= prio_reg;
            out_off_reg   <= off_reg;
        end
    end

    assign out_value = out_value_reg;
    assign out_prio  = out_prio_reg;
    assign out_off   = out_off_reg;

endmodule

@@ sv/gvi_ctrl.sv @@
// ----------------------------------------------------------------------------
// gvi_ctrl
// sequencer for loads and queries, output word handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gvi_ctrl import gvi_pkg::*; #(
    parameter int DIMS = DIMS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_tuser,
    output logic     m_tvalid,
    input  logic     m_tready,
    output gvi_cmd_t cmd,
    input  gvi_sts_t sts
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_QSTART = 5'd1;
    localparam logic [4:0] ST_QWAIT  = 5'd2;
    localparam logic [4:0] ST_QPOST  = 5'd3;
    localparam logic [4:0] ST_RDC    = 5'd4;
    localparam logic [4:0] ST_RDCW   = 5'd5;
    localparam logic [4:0] ST_RDN    = 5'd6;
    localparam logic [4:0] ST_RDNW   = 5'd7;
    localparam logic [4:0] ST_MULLO  = 5'd8;
    localparam logic [4:0] ST_MULHI  = 5'd9;
    localparam logic [4:0] ST_SUM    = 5'd10;
    localparam logic [4:0] ST_TSTART = 5'd11;
    localparam logic [4:0] ST_TWAIT  = 5'd12;
    localparam logic [4:0] ST_SAT    = 5'd13;
    localparam logic [4:0] ST_PRIO   = 5'd14;
    localparam logic [4:0] ST_PWAIT  = 5'd15;
    localparam logic [4:0] ST_DONE   = 5'd16;

    localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(DIMS - 1);

    logic [4:0]       state_reg, state_next;
    logic [DIM_W-1:0] dim_reg, dim_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        dim_next   = dim_reg;
        cmd        = '0;
        cmd.dim    = dim_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == CMD_LOAD) begin
                        cmd.mem_wr = 1'b1;
                    end else begin
                        cmd.cap_query = 1'b1;
                        dim_next      = '0;
                        state_next    = ST_QSTART;
                    end
                end
            end
            ST_QSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_QUANT;
                state_next    = ST_QWAIT;
            end
            ST_QWAIT: begin
                cmd.div_sel = DIV_QUANT;
                if (sts.div_done) begin
                    cmd.q_fix  = 1'b1;
                    state_next = ST_QPOST;
                end
            end
            ST_QPOST: begin
                cmd.q_post = 1'b1;
                if (dim_reg == DIM_LAST) begin
                    dim_next   = '0;
                    state_next = ST_RDC;
                end else begin
                    dim_next   = dim_reg + 1'b1;
                    state_next = ST_QSTART;
                end
            end
            ST_RDC: begin
                cmd.rd_centre = 1'b1;
                state_next    = ST_RDCW;
            end
            ST_RDCW: begin
                cmd.nn_latch = 1'b1;
                state_next   = ST_RDN;
            end
            ST_RDN: begin
                cmd.rd_nb  = 1'b1;
                state_next = ST_RDNW;
            end
            ST_RDNW: begin
                cmd.diff_latch = 1'b1;
                state_next     = ST_MULLO;
            end
            ST_MULLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MULHI;
            end
            ST_MULHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_TSTART;
            end
            ST_TSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TERM;
                state_next    = ST_TWAIT;
            end
            ST_TWAIT: begin
                cmd.div_sel = DIV_TERM;
                if (sts.div_done) begin
                    cmd.term_acc = 1'b1;
                    if (dim_reg == DIM_LAST) begin
                        state_next = ST_SAT;
                    end else begin
                        dim_next   = dim_reg + 1'b1;
                        state_next = ST_RDN;
                    end
                end
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_PRIO;
            end
            ST_PRIO: begin
                cmd.prio_eval = 1'b1;
                cmd.div_sel   = DIV_PRIO;
                if (sts.prio_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_PWAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PWAIT: begin
                cmd.div_sel = DIV_PRIO;
                if (sts.div_done) begin
                    cmd.prio_latch = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dim_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dim_reg       <= dim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `GVI_ASSERT(a_div_free, cmd.div_start |-> !sts.div_busy, "divider started while busy")
    `GVI_ASSERT(a_done_waited, sts.div_done |-> (state_reg == ST_QWAIT || state_reg == ST_TWAIT || state_reg == ST_PWAIT), "divider result outside a wait state")
    `GVI_ASSERT(a_out_from_done, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result word raised outside done")
    `GVI_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "result word valid after reset")

endmodule
